// ===== sv/srcs_pkg.sv =====
// Shared types, operation codes and register indexes for the split-read clip screen.
package srcs_pkg;

   // CIGAR operation codes used by the screen
   localparam logic [3:0] OP_MATCH = 4'd0;
   localparam logic [3:0] OP_DEL   = 4'd2;
   localparam logic [3:0] OP_SOFT  = 4'd4;
   localparam logic [3:0] OP_HARD  = 4'd5;

   // Configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_CLIPPING      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_MAP_QUALITY   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_UNCLIPPED_LEN = 2'd2;
   localparam int CSR_DATA_W = 16;

   // Reset values of the configuration registers
   localparam logic [15:0] RST_MIN_CLIPPING      = 16'd0;
   localparam logic [7:0]  RST_MIN_MAP_QUALITY   = 8'd20;
   localparam logic [15:0] RST_MIN_UNCLIPPED_LEN = 16'd500;

   localparam logic [15:0] OP_INDEX_MAX = 16'hFFFF;

   typedef struct packed {
      logic [3:0]  cigar_op;
      logic [27:0] op_length;
      logic        first_op;
      logic        last_op;
      logic [7:0]  map_quality;
      logic [30:0] ref_position;
      logic [30:0] read_length;
      logic        reverse_strand;
   } req_type;

   typedef struct packed {
      logic [30:0] ref_start;
      logic [31:0] ref_end;
      logic [27:0] left_clip;
      logic [27:0] right_clip;
      logic        strand_out;
      logic        report;
   } rsp_type;

   typedef struct packed {
      logic [15:0] min_clipping;
      logic [7:0]  min_map_quality;
      logic [15:0] min_unclipped_len;
   } cfg_type;

   // One finished record, handed from the tracker to the screen stage
   typedef struct packed {
      logic [30:0] ref_position;
      logic [31:0] span;
      logic [27:0] left_clip;
      logic [27:0] right_clip;
      logic [30:0] read_length;
      logic [7:0]  map_quality;
      logic        reverse_strand;
   } rec_type;

endpackage

// ===== sv/srcs_track.sv =====
// Per-record CIGAR tracker: span sum, clip capture and finished-record register.
module srcs_track (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_accept,
   input  srcs_pkg::req_type req_data,
   input  logic             rec_take,
   output logic             rec_valid,
   output srcs_pkg::rec_type rec_data
);

   logic [15:0] op_index_ff, op_index_in;
   logic        first_hard_ff, first_hard_in;
   logic [27:0] left_ff, left_in;
   logic [3:0]  prev_op_ff, prev_op_in;
   logic [27:0] prev_len_ff, prev_len_in;
   logic [31:0] span_ff, span_in;
   logic        rec_valid_ff, rec_valid_in;
   srcs_pkg::rec_type rec_ff, rec_in;

   logic [15:0] idx;
   logic        idx0;
   logic        base_hard;
   logic [27:0] base_left;
   logic [31:0] base_span;
   logic        new_hard;
   logic [27:0] new_left;
   logic [32:0] span_sum;
   logic [31:0] new_span;
   logic [27:0] right;
   logic [15:0] hard_ext;

   always_comb begin
      idx       = req_data.first_op ? 16'd0 : op_index_ff;
      idx0      = (idx == 16'd0);
      base_hard = idx0 ? 1'b0 : first_hard_ff;
      base_left = idx0 ? 28'd0 : left_ff;
      base_span = idx0 ? 32'd0 : span_ff;

      new_hard = idx0 ? (req_data.cigar_op == srcs_pkg::OP_HARD) : base_hard;
      if (idx0 && req_data.cigar_op == srcs_pkg::OP_SOFT) begin
         new_left = req_data.op_length;
      end else if (idx == 16'd1 && base_hard && req_data.cigar_op == srcs_pkg::OP_SOFT) begin
         new_left = req_data.op_length;
      end else begin
         new_left = base_left;
      end

      span_sum = {1'b0, base_span} + {5'd0, req_data.op_length};
      if (req_data.cigar_op == srcs_pkg::OP_MATCH || req_data.cigar_op == srcs_pkg::OP_DEL) begin
         new_span = span_sum[32] ? 32'hFFFF_FFFF : span_sum[31:0];
      end else begin
         new_span = base_span;
      end

      // right clip only from an operation past the one that gave the left clip
      hard_ext = {15'd0, new_hard};
      right    = 28'd0;
      if (idx > hard_ext) begin
         if (req_data.cigar_op == srcs_pkg::OP_HARD) begin
            if (idx > hard_ext + 16'd1 && prev_op_ff == srcs_pkg::OP_SOFT) begin
               right = prev_len_ff;
            end
         end else if (req_data.cigar_op == srcs_pkg::OP_SOFT) begin
            right = req_data.op_length;
         end
      end
   end

   always_comb begin
      op_index_in   = op_index_ff;
      first_hard_in = first_hard_ff;
      left_in       = left_ff;
      prev_op_in    = prev_op_ff;
      prev_len_in   = prev_len_ff;
      span_in       = span_ff;
      rec_valid_in  = rec_valid_ff && !rec_take;
      rec_in        = rec_ff;
      if (req_accept) begin
         if (req_data.last_op) begin
            op_index_in   = 16'd0;
            first_hard_in = 1'b0;
            left_in       = 28'd0;
            prev_op_in    = 4'd0;
            prev_len_in   = 28'd0;
            span_in       = 32'd0;
            rec_valid_in  = 1'b1;
            rec_in.ref_position   = req_data.ref_position;
            rec_in.span           = new_span;
            rec_in.left_clip      = new_left;
            rec_in.right_clip     = right;
            rec_in.read_length    = req_data.read_length;
            rec_in.map_quality    = req_data.map_quality;
            rec_in.reverse_strand = req_data.reverse_strand;
         end else begin
            op_index_in   = (idx < srcs_pkg::OP_INDEX_MAX) ? idx + 16'd1 : srcs_pkg::OP_INDEX_MAX;
            first_hard_in = new_hard;
            left_in       = new_left;
            prev_op_in    = req_data.cigar_op;
            prev_len_in   = req_data.op_length;
            span_in       = new_span;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_index_ff   <= 16'd0;
         first_hard_ff <= 1'b0;
         left_ff       <= 28'd0;
         prev_op_ff    <= 4'd0;
         prev_len_ff   <= 28'd0;
         span_ff       <= 32'd0;
         rec_valid_ff  <= 1'b0;
      end else begin
         op_index_ff   <= op_index_in;
         first_hard_ff <= first_hard_in;
         left_ff       <= left_in;
         prev_op_ff    <= prev_op_in;
         prev_len_ff   <= prev_len_in;
         span_ff       <= span_in;
         rec_valid_ff  <= rec_valid_in;
      end
      rec_ff <= rec_in;
   end

   assign rec_valid = rec_valid_ff;
   assign rec_data  = rec_ff;

endmodule

// ===== sv/srcs_screen.sv =====
// Record screen: reference end, aligned length test and the result register.
module srcs_screen (
   input  logic              clock,
   input  logic              reset,
   input  srcs_pkg::cfg_type cfg,
   input  logic              rec_valid,
   input  srcs_pkg::rec_type rec_data,
   output logic              rec_take,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output srcs_pkg::rsp_type rsp_data
);

   logic              rsp_valid_ff, rsp_valid_in;
   srcs_pkg::rsp_type rsp_ff, rsp_in;

   logic [32:0]        end_sum;
   logic signed [32:0] aligned;
   logic               len_ok;
   logic               clip_ok;
   logic               qual_ok;
   logic               advance;

   always_comb begin
      end_sum = {2'd0, rec_data.ref_position} + {1'b0, rec_data.span};
      aligned = $signed({2'd0, rec_data.read_length})
              - $signed({5'd0, rec_data.left_clip})
              - $signed({5'd0, rec_data.right_clip});
      len_ok  = aligned >= $signed({17'd0, cfg.min_unclipped_len});
      clip_ok = (rec_data.left_clip > {12'd0, cfg.min_clipping})
             || (rec_data.right_clip > {12'd0, cfg.min_clipping});
      qual_ok = rec_data.map_quality >= cfg.min_map_quality;

      advance  = !rsp_valid_ff || rsp_ready;
      rec_take = rec_valid && advance;

      rsp_valid_in = advance ? rec_valid : rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rec_take) begin
         rsp_in.ref_start  = rec_data.ref_position;
         rsp_in.ref_end    = end_sum[32] ? 32'hFFFF_FFFF : end_sum[31:0];
         rsp_in.left_clip  = rec_data.left_clip;
         rsp_in.right_clip = rec_data.right_clip;
         rsp_in.strand_out = rec_data.reverse_strand;
         rsp_in.report     = qual_ok && len_ok && clip_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== sv/split_read_clip_screen.sv =====
// Each operation is folded into the record state in the cycle it transfers; a record's last one
// fills the finished-record register, then the screen stage registers the result. Throughput: one
// CIGAR operation per cycle while the finished-record register is free or drains that cycle.
// Reset (synchronous, active high) clears the record state and both stage valids and
// loads the thresholds with min_clipping 0, min_map_quality 20, min_unclipped_len 500.
module split_read_clip_screen (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  srcs_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output srcs_pkg::rsp_type                   rsp_data,
   input  logic                                csr_we,
   input  logic [srcs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [srcs_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   // Threshold registers
   srcs_pkg::cfg_type cfg_ff, cfg_in;

   logic              req_accept;
   logic              rec_valid;
   logic              rec_take;
   srcs_pkg::rec_type rec_data;

   // Decode a write; an index past the register list is dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            srcs_pkg::CSR_MIN_CLIPPING:      cfg_in.min_clipping      = csr_wdata;
            srcs_pkg::CSR_MIN_MAP_QUALITY:   cfg_in.min_map_quality   = csr_wdata[7:0];
            srcs_pkg::CSR_MIN_UNCLIPPED_LEN: cfg_in.min_unclipped_len = csr_wdata;
            default:                         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_clipping      <= srcs_pkg::RST_MIN_CLIPPING;
         cfg_ff.min_map_quality   <= srcs_pkg::RST_MIN_MAP_QUALITY;
         cfg_ff.min_unclipped_len <= srcs_pkg::RST_MIN_UNCLIPPED_LEN;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Take an operation whenever the finished-record register is free or drains this
   // cycle; a stalled result output backs up through that register only.
   assign req_ready  = !rec_valid || rec_take;
   assign req_accept = req_valid && req_ready;

   // Fold each transfer into the running record; hold the finished record for the screen.
   srcs_track u_track (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_data   (req_data),
      .rec_take   (rec_take),
      .rec_valid  (rec_valid),
      .rec_data   (rec_data)
   );

   // Compute the end coordinate and the report flag, then register the result.
   srcs_screen u_screen (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .rec_valid (rec_valid),
      .rec_data  (rec_data),
      .rec_take  (rec_take),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the split-read clip screen: CIGAR stream in, record screen out.
`timescale 1ns / 1ps

module tb_top;

   // CIGAR codes the package leaves out
   localparam logic [3:0] OP_INS      = 4'd1;
   localparam logic [3:0] OP_SKIP     = 4'd3;
   localparam logic [3:0] OP_PAD      = 4'd6;
   localparam logic [3:0] OP_EQ       = 4'd7;
   localparam logic [3:0] OP_DIFF     = 4'd8;
   localparam logic [3:0] OP_UNDEF_LO = 4'd9;
   localparam logic [3:0] OP_CODE_TOP = 4'd15;

   localparam logic [27:0] LEN_MAX     = 28'hFFFFFFF;
   localparam logic [30:0] FIELD31_MAX = 31'h7FFFFFFF;

   localparam int STALL_LIMIT     = 2000;   // cycles without any transfer
   localparam int HOLD_CYCLES     = 300;    // long receiver hold-off
   localparam int DRAIN_CYCLES    = 4;      // settling margin after the last result
   localparam int LONG_RECORD_OPS = 80;     // enough to pin the span at its ceiling

   typedef enum int {RX_FREE, RX_COIN, RX_SLOW, RX_BEAT} rx_mode_type;

   logic                            clock     = 1'b0;
   logic                            reset     = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   srcs_pkg::req_type               req_data  = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   srcs_pkg::rsp_type               rsp_data;
   logic                            csr_we    = 1'b0;
   logic [srcs_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [srcs_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // Thresholds as the block should hold them
   logic [15:0] thr_min_clip    = srcs_pkg::RST_MIN_CLIPPING;
   logic [7:0]  thr_min_mapq    = srcs_pkg::RST_MIN_MAP_QUALITY;
   logic [15:0] thr_min_aligned = srcs_pkg::RST_MIN_UNCLIPPED_LEN;

   // Record being assembled from the CIGAR stream
   logic [15:0] rec_op_index   = '0;
   logic        rec_first_hard = 1'b0;
   logic [27:0] rec_left_clip  = '0;
   logic [3:0]  rec_prev_op    = '0;
   logic [27:0] rec_prev_len   = '0;
   logic [31:0] rec_span       = '0;

   srcs_pkg::rsp_type pending_screens[$];
   int      error_count      = 0;
   bit      sender_bursty    = 1'b1;
   int      burst_left       = 0;
   bit      hold_rsp_request = 1'b0;

   split_read_clip_screen i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------------------------
   function automatic logic [31:0] add_saturating(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFFFFFF : s[31:0];
   endfunction

   task automatic clear_record_state();
      rec_op_index   = '0;
      rec_first_hard = 1'b0;
      rec_left_clip  = '0;
      rec_prev_op    = '0;
      rec_prev_len   = '0;
      rec_span       = '0;
   endtask

   // Fold one transferred CIGAR operation into the record; queue the screen on the last one.
   task automatic fold_cigar_op(input srcs_pkg::req_type r);
      logic [15:0]       idx;
      logic [27:0]       right;
      longint            unclipped;
      srcs_pkg::rsp_type screen;
      // first_op restarts the record; position 0 always starts clean
      if (r.first_op) rec_op_index = '0;
      idx = rec_op_index;
      if (idx == 16'd0) clear_record_state();

      // left clip: first op, or second op behind a leading hard clip
      if (idx == 16'd0) begin
         if (r.cigar_op == srcs_pkg::OP_HARD) rec_first_hard = 1'b1;
         else if (r.cigar_op == srcs_pkg::OP_SOFT) rec_left_clip = r.op_length;
      end else if (idx == 16'd1 && rec_first_hard && r.cigar_op == srcs_pkg::OP_SOFT) begin
         rec_left_clip = r.op_length;
      end

      if (r.cigar_op == srcs_pkg::OP_MATCH || r.cigar_op == srcs_pkg::OP_DEL)
         rec_span = add_saturating(rec_span, 32'(r.op_length));

      if (!r.last_op) begin
         rec_prev_op  = r.cigar_op;
         rec_prev_len = r.op_length;
         // saturate the position instead of wrapping back to a record start
         if (idx != srcs_pkg::OP_INDEX_MAX) rec_op_index = idx + 16'd1;
      end else begin
         // right clip only from an op beyond the one that gave the left clip
         right = '0;
         if (idx > {15'd0, rec_first_hard}) begin
            if (r.cigar_op == srcs_pkg::OP_HARD) begin
               if (idx - 16'd1 > {15'd0, rec_first_hard}
                   && rec_prev_op == srcs_pkg::OP_SOFT)
                  right = rec_prev_len;
            end else if (r.cigar_op == srcs_pkg::OP_SOFT) begin
               right = r.op_length;
            end
         end
         unclipped = longint'(r.read_length) - longint'(rec_left_clip) - longint'(right);
         screen.ref_start  = r.ref_position;
         screen.ref_end    = add_saturating({1'b0, r.ref_position}, rec_span);
         screen.left_clip  = rec_left_clip;
         screen.right_clip = right;
         screen.strand_out = r.reverse_strand;
         screen.report     = (r.map_quality >= thr_min_mapq)
                             && (unclipped >= longint'(thr_min_aligned))
                             && (rec_left_clip > 28'(thr_min_clip) || right > 28'(thr_min_clip));
         pending_screens.push_back(screen);
         clear_record_state();
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // Result checking: compare every result transfer against the oldest queued screen
   // ---------------------------------------------------------------------------------------
   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin : check_screens
      srcs_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_screens.size() == 0) begin
            $display("%0t: result with nothing expected: expected none, actual 0x%0h",
                     $time, rsp_data);
            error_count++;
         end else begin
            want = pending_screens.pop_front();
            check_field("ref_start",  32'(want.ref_start),  32'(rsp_data.ref_start));
            check_field("ref_end",    want.ref_end,         rsp_data.ref_end);
            check_field("left_clip",  32'(want.left_clip),  32'(rsp_data.left_clip));
            check_field("right_clip", 32'(want.right_clip), 32'(rsp_data.right_clip));
            check_field("strand_out", 32'(want.strand_out), 32'(rsp_data.strand_out));
            check_field("report",     32'(want.report),     32'(rsp_data.report));
         end
      end
   end

   // Watchdog: end the run if neither channel moves for too long
   int idle_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == STALL_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Receiver: switch between stall patterns on its own; honor a requested long hold-off
   // ---------------------------------------------------------------------------------------
   rx_mode_type rsp_mode      = RX_FREE;
   int          rsp_mode_left = 0;
   int          rsp_hold_left = 0;
   int          rsp_beat      = 0;

   always @(negedge clock) begin
      if (hold_rsp_request) begin
         hold_rsp_request = 1'b0;
         rsp_hold_left    = HOLD_CYCLES;
      end
      if (rsp_mode_left == 0) begin
         rsp_mode      = rx_mode_type'($urandom_range(0, 3));
         rsp_mode_left = $urandom_range(20, 150);
      end else begin
         rsp_mode_left--;
      end
      rsp_beat++;
      if (rsp_hold_left > 0) begin
         rsp_hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         case (rsp_mode)
            RX_FREE: rsp_ready <= 1'b1;
            RX_COIN: rsp_ready <= 1'($urandom_range(0, 1));
            RX_SLOW: rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= ((rsp_beat % 7) < 3);
         endcase
      end
   end

   // ---------------------------------------------------------------------------------------
   // Sender and configuration
   // ---------------------------------------------------------------------------------------
   function automatic srcs_pkg::req_type with_op(input srcs_pkg::req_type rec,
                                                 input logic [3:0] op,
                                                 input logic [27:0] len, input bit first,
                                                 input bit last);
      srcs_pkg::req_type r;
      r           = rec;
      r.cigar_op  = op;
      r.op_length = len;
      r.first_op  = first;
      r.last_op   = last;
      return r;
   endfunction

   // Offer one operation and hold it until it transfers; idle first at a burst boundary.
   task automatic send_op(input srcs_pkg::req_type r);
      int gap;
      gap = 0;
      if (sender_bursty) begin
         if (burst_left == 0) begin
            gap        = $urandom_range(0, 8);
            burst_left = $urandom_range(1, 40);
         end else begin
            burst_left--;
         end
      end
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      fold_cigar_op(r);
   endtask

   // Drop valid and wait until every queued screen has come back.
   task automatic wait_for_screens();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_screens.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [srcs_pkg::CSR_IDX_W-1:0] index,
                            input logic [srcs_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      case (index)
         srcs_pkg::CSR_MIN_CLIPPING:      thr_min_clip    = data;
         srcs_pkg::CSR_MIN_MAP_QUALITY:   thr_min_mapq    = data[7:0];
         srcs_pkg::CSR_MIN_UNCLIPPED_LEN: thr_min_aligned = data;
         default: ;
      endcase
   endtask

   // Write all thresholds once the block has gone quiet.
   task automatic set_thresholds(input logic [15:0] clip, input logic [7:0] mapq,
                                 input logic [15:0] aligned);
      wait_for_screens();
      write_csr(srcs_pkg::CSR_MIN_CLIPPING, clip);
      // upper bits of the quality write are junk the register must drop
      write_csr(srcs_pkg::CSR_MIN_MAP_QUALITY, {8'($urandom), mapq});
      write_csr(srcs_pkg::CSR_MIN_UNCLIPPED_LEN, aligned);
   endtask

   function automatic logic [27:0] pick_length();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return 28'($urandom);
         default: return 28'($urandom_range(1, 400));
      endcase
   endfunction

   // One record. Well formed: [H] [S] body... [S] [H]. Broken: random codes and flags.
   task automatic send_record(input bit broken, input bit force_first);
      srcs_pkg::req_type rec;
      logic [3:0]        ops[$];
      logic [27:0]       lens[$];
      longint            clipped;
      int                n;
      bit                first;
      bit                last;
      rec                = '0;
      rec.map_quality    = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                       : 8'($urandom_range(10, 40));
      rec.ref_position   = ($urandom_range(0, 1) == 0) ? 31'($urandom)
                                                       : 31'($urandom_range(0, 100000));
      rec.reverse_strand = 1'($urandom);
      clipped            = 0;
      if (broken) begin
         n = $urandom_range(1, 6);
         repeat (n) begin
            ops.push_back(4'($urandom));
            lens.push_back(pick_length());
         end
      end else begin
         if ($urandom_range(0, 2) == 0) begin
            ops.push_back(srcs_pkg::OP_HARD);
            lens.push_back(pick_length());
         end
         if ($urandom_range(0, 3) != 0) begin
            ops.push_back(srcs_pkg::OP_SOFT);
            lens.push_back(pick_length());
            clipped += lens[$];
         end
         n = $urandom_range(1, 4);
         repeat (n) begin
            ops.push_back(($urandom_range(0, 2) != 0) ? srcs_pkg::OP_MATCH : 4'($urandom));
            lens.push_back(($urandom_range(0, 7) == 0) ? 28'($urandom)
                                                       : 28'($urandom_range(1, 1500)));
         end
         if ($urandom_range(0, 2) != 0) begin
            ops.push_back(srcs_pkg::OP_SOFT);
            lens.push_back(pick_length());
            clipped += lens[$];
         end
         if ($urandom_range(0, 2) == 0) begin
            ops.push_back(srcs_pkg::OP_HARD);
            lens.push_back(pick_length());
         end
      end
      // read length mostly near the pass line; sometimes random or shorter than the clips
      case ($urandom_range(0, 9))
         0:       rec.read_length = 31'($urandom);
         1:       rec.read_length = 31'($urandom_range(0, 50));
         default: rec.read_length = 31'(clipped + longint'($urandom_range(0, 1200)));
      endcase
      foreach (ops[i]) begin
         if (broken) begin
            first = ($urandom_range(0, 4) == 0);
            last  = (i == ops.size() - 1) ? 1'($urandom_range(0, 1))
                                          : ($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 1) == 0) begin
               rec.map_quality  = 8'($urandom);
               rec.ref_position = 31'($urandom);
               rec.read_length  = 31'($urandom);
            end
         end else begin
            // leave first_op off now and then: a record also starts after a last op
            first = (i == 0) && (force_first || $urandom_range(0, 3) != 0);
            last  = (i == ops.size() - 1);
         end
         send_op(with_op(rec, ops[i], lens[i], first, last));
      end
   endtask

   // Random records, mostly well formed, closed by a clean record so the phase ends tidy.
   task automatic run_records(input int count);
      repeat (count) send_record($urandom_range(0, 9) == 0, 1'b0);
      send_record(1'b0, 1'b1);
   endtask

   // ---------------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------------
   task automatic test_directed();
      srcs_pkg::req_type rec;
      rec              = '0;
      rec.map_quality  = 8'd20;
      rec.ref_position = 31'd1000;
      rec.read_length  = 31'd1200;
      // soft clips at both ends, quality exactly at the reset minimum
      send_op(with_op(rec, srcs_pkg::OP_SOFT, 28'd100, 1'b1, 1'b0));
      send_op(with_op(rec, srcs_pkg::OP_MATCH, 28'd1000, 1'b0, 1'b0));
      send_op(with_op(rec, srcs_pkg::OP_SOFT, 28'd50, 1'b0, 1'b1));
      // hard clips outside soft clips, quality one below; starts without first_op
      rec.map_quality    = 8'd19;
      rec.reverse_strand = 1'b1;
      send_op(with_op(rec, srcs_pkg::OP_HARD, 28'd10, 1'b0, 1'b0));
      send_op(with_op(rec, srcs_pkg::OP_SOFT, 28'd300, 1'b0, 1'b0));
      send_op(with_op(rec, srcs_pkg::OP_DEL, 28'd800, 1'b0, 1'b0));
      send_op(with_op(rec, srcs_pkg::OP_SOFT, 28'd20, 1'b0, 1'b0));
      send_op(with_op(rec, srcs_pkg::OP_HARD, 28'd5, 1'b0, 1'b1));
      // lone hard clip with every record field at zero gives no clip
      send_op(with_op('0, srcs_pkg::OP_HARD, 28'd7, 1'b1, 1'b1));
      // one full-length soft clip: left only, unclipped length goes negative
      rec             = '0;
      rec.map_quality = 8'hFF;
      send_op(with_op(rec, srcs_pkg::OP_SOFT, LEN_MAX, 1'b1, 1'b1));
      // soft clip between two hard clips counts on the left only
      send_op(with_op(rec, srcs_pkg::OP_HARD, 28'd1, 1'b1, 1'b0));
      send_op(with_op(rec, srcs_pkg::OP_SOFT, 28'd9, 1'b0, 1'b0));
      send_op(with_op(rec, srcs_pkg::OP_HARD, 28'd2, 1'b0, 1'b1));
      // abandon a record midway: the second first_op restarts it
      send_op(with_op(rec, srcs_pkg::OP_MATCH, 28'd4, 1'b1, 1'b0));
      send_op(with_op(rec, srcs_pkg::OP_SOFT, 28'd5, 1'b1, 1'b0));
      send_op(with_op(rec, srcs_pkg::OP_HARD, 28'd3, 1'b0, 1'b1));
      // widest position, read length and op lengths
      rec.ref_position   = FIELD31_MAX;
      rec.read_length    = FIELD31_MAX;
      rec.reverse_strand = 1'b1;
      send_op(with_op(rec, srcs_pkg::OP_MATCH, LEN_MAX, 1'b1, 1'b0));
      send_op(with_op(rec, srcs_pkg::OP_DEL, LEN_MAX, 1'b0, 1'b0));
      send_op(with_op(rec, srcs_pkg::OP_MATCH, LEN_MAX, 1'b0, 1'b1));
      // ops that neither span nor clip, undefined codes among them
      rec             = '0;
      rec.read_length = 31'd600;
      rec.map_quality = 8'd30;
      send_op(with_op(rec, OP_INS, 28'd10, 1'b1, 1'b0));
      send_op(with_op(rec, OP_SKIP, 28'd11, 1'b0, 1'b0));
      send_op(with_op(rec, OP_PAD, 28'd12, 1'b0, 1'b0));
      send_op(with_op(rec, OP_EQ, 28'd13, 1'b0, 1'b0));
      send_op(with_op(rec, OP_DIFF, 28'd14, 1'b0, 1'b0));
      send_op(with_op(rec, OP_UNDEF_LO, 28'd15, 1'b0, 1'b0));
      send_op(with_op(rec, OP_UNDEF_LO + 4'd3, 28'd16, 1'b0, 1'b0));
      send_op(with_op(rec, OP_CODE_TOP, 28'd17, 1'b0, 1'b1));
      wait_for_screens();
   endtask

   task automatic test_thresholds();
      // loosest, then tightest, then a few in the interesting range
      set_thresholds(16'h0000, 8'h00, 16'h0000);
      run_records(35);
      set_thresholds(16'hFFFF, 8'hFF, 16'hFFFF);
      run_records(20);
      repeat (3) begin
         set_thresholds(16'($urandom_range(0, 300)), 8'($urandom_range(0, 40)),
                        16'($urandom_range(0, 1500)));
         run_records(25);
      end
      set_thresholds(16'($urandom), 8'($urandom), 16'($urandom));
      run_records(12);
      set_thresholds(16'($urandom_range(0, 100)), 8'($urandom_range(0, 30)),
                     16'($urandom_range(0, 800)));
   endtask

   task automatic test_backpressure();
      // hold off the receiver while the sender streams without gaps: input must stall
      sender_bursty    = 1'b0;
      hold_rsp_request = 1'b1;
      run_records(20);
      sender_bursty = 1'b1;
      // pause the sender until every screen is back, then resume
      wait_for_screens();
      run_records(12);
      wait_for_screens();
   endtask

   task automatic test_long_record();
      srcs_pkg::req_type rec;
      rec                = '0;
      rec.map_quality    = 8'($urandom);
      rec.ref_position   = 31'($urandom);
      rec.read_length    = 31'($urandom);
      rec.reverse_strand = 1'($urandom);
      // run the span and the end into their ceilings
      sender_bursty = 1'b0;
      send_op(with_op(rec, srcs_pkg::OP_HARD, pick_length(), 1'b1, 1'b0));
      send_op(with_op(rec, srcs_pkg::OP_SOFT, 28'($urandom_range(100, 400)), 1'b0, 1'b0));
      repeat (LONG_RECORD_OPS)
         send_op(with_op(rec, ($urandom_range(0, 1) == 0) ? srcs_pkg::OP_MATCH
                                                          : 4'($urandom),
                         28'($urandom), 1'b0, 1'b0));
      send_op(with_op(rec, srcs_pkg::OP_SOFT, 28'($urandom_range(100, 400)), 1'b0, 1'b0));
      send_op(with_op(rec, srcs_pkg::OP_HARD, pick_length(), 1'b0, 1'b1));
      sender_bursty = 1'b1;
      wait_for_screens();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_thresholds();
      test_backpressure();
      test_long_record();

      // drain and let the result register settle before the verdict
      wait_for_screens();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/srcs_pkg.sv
sv/srcs_track.sv
sv/srcs_screen.sv
sv/split_read_clip_screen.sv
tb/tb_top.sv
